// ===== rtl/debug_run_control_macros.svh =====
// Assertion macros shared by the debug run control RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef DEBUG_RUN_CONTROL_MACROS_SVH
`define DEBUG_RUN_CONTROL_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define DRC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequence holds in the same cycle as the antecedent.
`define DRC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define DRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/drc_pkg.sv =====
// Shared types and constants for the debug run control block.
// No dependencies; every other file but drc_ram and the macros header imports this package.
package drc_pkg;

    localparam int BP_ENTRIES_DFLT  = 16;
    localparam int TRACE_DEPTH_DFLT = 32;
    localparam int MEM_BYTES        = 4096;
    localparam int ADDR_EXT_W       = 17;

    localparam int PC_W    = 12;
    localparam int SP_W    = 5;
    localparam int WORD_W  = 16;
    localparam int IDX_W   = 5;
    localparam int COUNT_W = 6;
    localparam int TICK_W  = 10;
    localparam int TICK_CAP = 1000;
    localparam logic [TICK_W-1:0] PACE_RESET = TICK_W'(2);

    localparam int CFG_ADDR_W = 3;
    localparam logic CFG_IDX_PACE = 1'b0;

    localparam logic [3:0] MODE_TICK      = 4'd0;
    localparam logic [3:0] MODE_BP_ADD    = 4'd1;
    localparam logic [3:0] MODE_BP_REMOVE = 4'd2;
    localparam logic [3:0] MODE_BP_CLEAR  = 4'd3;
    localparam logic [3:0] MODE_STEP      = 4'd4;
    localparam logic [3:0] MODE_STEP_OVER = 4'd5;
    localparam logic [3:0] MODE_RESUME    = 4'd6;
    localparam logic [3:0] MODE_PAUSE     = 4'd7;
    localparam logic [3:0] MODE_RUN_ONE   = 4'd8;
    localparam logic [3:0] MODE_RETIRE    = 4'd9;
    localparam logic [3:0] MODE_READ_TRC  = 4'd10;

    typedef struct packed {
        logic [3:0]        mode;
        logic [PC_W-1:0]   cur_pc;
        logic [SP_W-1:0]   cur_sp;
        logic [WORD_W-1:0] fetched_word;
        logic [IDX_W-1:0]  trace_index;
    } drc_in_t;

    typedef struct packed {
        logic               execute_now;
        logic               running;
        logic               stepping_over;
        logic               step_over_waiting;
        logic               hit_breakpoint;
        logic               status;
        logic [PC_W-1:0]    trace_pc;
        logic [WORD_W-1:0]  trace_word;
        logic [COUNT_W-1:0] trace_count;
    } drc_out_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic capture;
        logic load_out;
    } drc_cmd_t;

    typedef struct packed {
        logic is_read;
    } drc_stat_t;

endpackage

// ===== rtl/debug_run_control.sv =====
// Top level of the debug run control block: APB register, sequencer and datapath.
// Depends on drc_pkg, drc_ctrl, drc_dpath (and through it drc_ram).
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in      | request   | in_valid / in_stall | drc_in_t: mode, pc, sp, word, idx
//  out     | result    | out_valid/out_stall | drc_out_t: grant, flags, trace
//  apb     | config    | psel/penable/pready | pace_interval_ticks at offset 0
//
// One request at a time: the sequencer latches, executes and delivers in turn, and
// a trace read adds a capture step for the registered RAM port.
// A request is taken while the previous result still waits in the output register;
// a stalled result holds the sequencer in its deliver step.
// rst_n clears all control state at once; breakpoint addresses and the trace RAM
// are not cleared and need no sweep.
module debug_run_control #(
    parameter int BP_ENTRIES  = drc_pkg::BP_ENTRIES_DFLT,
    parameter int TRACE_DEPTH = drc_pkg::TRACE_DEPTH_DFLT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  drc_pkg::drc_in_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output drc_pkg::drc_out_t                out_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [drc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import drc_pkg::*;

    logic [TICK_W-1:0] pace_reg;
    drc_cmd_t          cmd;
    drc_stat_t         stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pace_reg <= PACE_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_PACE))
        begin
            pace_reg <= pwdata[TICK_W-1:0];
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_PACE) ? 32'(pace_reg) : '0;

    drc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    drc_dpath #(
        .BP_ENTRIES  (BP_ENTRIES),
        .TRACE_DEPTH (TRACE_DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (in_data),
        .pace     (pace_reg),
        .out_data (out_data)
    );

endmodule

// ===== rtl/drc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module drc_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/drc_ctrl.sv =====
// Sequencer for the debug run control block: accept, execute, trace read, deliver.
// Depends on drc_pkg for the command and status structs.
module drc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  drc_pkg::drc_stat_t  stat,
    output drc_pkg::drc_cmd_t   cmd
);
    import drc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_READ = 4'b0100,
        ST_DONE = 4'b1000
    } drc_state_t;

    drc_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.is_read ? ST_READ : ST_DONE;
            end
            ST_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                // hold the result until the output register frees up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/drc_dpath.sv =====
// Datapath: breakpoint table, run flags, pacing counter, trace ring and result registers.
// Depends on drc_pkg, drc_ram and the assertion macros header.
`include "debug_run_control_macros.svh"

module drc_dpath #(
    parameter int BP_ENTRIES  = drc_pkg::BP_ENTRIES_DFLT,
    parameter int TRACE_DEPTH = drc_pkg::TRACE_DEPTH_DFLT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  drc_pkg::drc_cmd_t             cmd,
    output drc_pkg::drc_stat_t            stat,
    input  drc_pkg::drc_in_t              in_data,
    input  logic [drc_pkg::TICK_W-1:0]    pace,
    output drc_pkg::drc_out_t             out_data
);
    import drc_pkg::*;

    localparam int TW = $clog2(TRACE_DEPTH);
    localparam int FW = $clog2(TRACE_DEPTH + 1);
    localparam int PW = ((TW > IDX_W) ? TW : IDX_W) + 2;
    localparam int RW = PC_W + WORD_W;

    drc_in_t  item_reg;
    drc_out_t res_reg, res_next;
    drc_out_t out_reg;

    logic [BP_ENTRIES-1:0] bp_valid_reg, bp_valid_next;
    logic [PC_W-1:0]       bp_addr_reg [BP_ENTRIES];
    logic [BP_ENTRIES-1:0] bp_match;
    logic [BP_ENTRIES-1:0] bp_free_oh;
    logic                  bp_write;

    logic              run_reg, run_next;
    logic              ss_reg, ss_next;
    logic              skip_reg, skip_next;
    logic              oact_reg, oact_next;
    logic              opend_reg, opend_next;
    logic [SP_W-1:0]   tgt_reg, tgt_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] interval;

    logic [TW-1:0] head_reg;
    logic [FW-1:0] fill_reg;
    logic          rd_ok_reg;

    logic          grant;
    logic          hit;
    logic          full;
    logic          rd_ok;
    logic [PW-1:0] pos_sum;
    logic [PW-1:0] pos_wrap;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_rdata;
    logic [WORD_W-1:0] rec_word;

    always_comb
    begin
        for (int i = 0; i < BP_ENTRIES; i++)
        begin
            bp_match[i] = bp_valid_reg[i] && (bp_addr_reg[i] == item_reg.cur_pc);
        end
    end

    // lowest free slot as a one-hot vector
    assign bp_free_oh = ~bp_valid_reg & (bp_valid_reg + 1'b1);

    always_comb
    begin
        if (pace == '0)
        begin
            interval = TICK_W'(1);
        end
        else if (pace > TICK_W'(TICK_CAP))
        begin
            interval = TICK_W'(TICK_CAP);
        end
        else
        begin
            interval = pace;
        end
    end

    assign tick_inc = (ticks_reg < TICK_W'(TICK_CAP)) ? ticks_reg + 1'b1 : ticks_reg;

    always_comb
    begin
        run_next      = run_reg;
        ss_next       = ss_reg;
        skip_next     = skip_reg;
        oact_next     = oact_reg;
        opend_next    = opend_reg;
        tgt_next      = tgt_reg;
        ticks_next    = ticks_reg;
        bp_valid_next = bp_valid_reg;
        bp_write      = 1'b0;
        grant         = 1'b0;
        hit           = 1'b0;
        full          = 1'b0;
        unique case (item_reg.mode)
            MODE_TICK:
            begin
                ticks_next = tick_inc;
                if (opend_reg)
                begin
                    opend_next = 1'b0;
                    oact_next  = 1'b1;
                    tgt_next   = item_reg.cur_sp;
                    run_next   = 1'b1;
                    skip_next  = 1'b1;
                end
                if (!run_next)
                begin
                    if (ss_reg)
                    begin
                        ss_next = 1'b0;
                        grant   = 1'b1;
                    end
                end
                else if (tick_inc >= interval)
                begin
                    if (|bp_match)
                    begin
                        if (skip_next)
                        begin
                            skip_next = 1'b0;
                        end
                        else
                        begin
                            run_next  = 1'b0;
                            oact_next = 1'b0;
                            hit       = 1'b1;
                        end
                    end
                    grant = run_next;
                end
            end
            MODE_BP_ADD:
            begin
                if (!(|bp_match))
                begin
                    if (&bp_valid_reg)
                    begin
                        full = 1'b1;
                    end
                    else
                    begin
                        bp_valid_next = bp_valid_reg | bp_free_oh;
                        bp_write      = 1'b1;
                    end
                end
            end
            MODE_BP_REMOVE:
            begin
                bp_valid_next = bp_valid_reg & ~bp_match;
            end
            MODE_BP_CLEAR:
            begin
                bp_valid_next = '0;
            end
            MODE_STEP:
            begin
                if (!run_reg)
                begin
                    ss_next = 1'b1;
                end
            end
            MODE_STEP_OVER:
            begin
                if (!run_reg && !oact_reg && !opend_reg)
                begin
                    opend_next = 1'b1;
                end
            end
            MODE_RESUME:
            begin
                if (!run_reg)
                begin
                    run_next  = 1'b1;
                    skip_next = 1'b1;
                end
            end
            MODE_PAUSE:
            begin
                if (run_reg)
                begin
                    run_next   = 1'b0;
                    oact_next  = 1'b0;
                    opend_next = 1'b0;
                end
            end
            MODE_RUN_ONE:
            begin
                if (run_reg)
                begin
                    if (|bp_match)
                    begin
                        if (skip_reg)
                        begin
                            skip_next = 1'b0;
                        end
                        else
                        begin
                            run_next  = 1'b0;
                            oact_next = 1'b0;
                            hit       = 1'b1;
                        end
                    end
                    grant = run_next;
                end
            end
            MODE_RETIRE:
            begin
                if (oact_reg && (item_reg.cur_sp <= tgt_reg))
                begin
                    oact_next = 1'b0;
                    run_next  = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        if (grant)
        begin
            ticks_next = '0;
        end
    end

    // drop the recorded word when the instruction runs past the top of memory
    assign rec_word = ((ADDR_EXT_W'(item_reg.cur_pc) + 1'b1) < ADDR_EXT_W'(MEM_BYTES))
                      ? item_reg.fetched_word : '0;
    assign ram_wdata = {item_reg.cur_pc, rec_word};

    assign rd_ok    = PW'(item_reg.trace_index) < PW'(fill_reg);
    assign pos_sum  = PW'(head_reg) + PW'(TRACE_DEPTH) - PW'(fill_reg)
                      + PW'(item_reg.trace_index);
    assign pos_wrap = (pos_sum >= PW'(TRACE_DEPTH)) ? pos_sum - PW'(TRACE_DEPTH) : pos_sum;

    drc_ram #(
        .WIDTH (RW),
        .DEPTH (TRACE_DEPTH)
    ) u_trace_ram (
        .clk   (clk),
        .we    (cmd.exec && grant),
        .waddr (head_reg),
        .wdata (ram_wdata),
        .raddr (pos_wrap[TW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        res_next = res_reg;
        if (cmd.exec)
        begin
            res_next.execute_now       = grant;
            res_next.running           = run_next;
            res_next.stepping_over     = oact_next;
            res_next.step_over_waiting = opend_next;
            res_next.hit_breakpoint    = hit;
            res_next.status            = full;
            res_next.trace_pc          = '0;
            res_next.trace_word        = '0;
            if (grant && (fill_reg < FW'(TRACE_DEPTH)))
            begin
                res_next.trace_count = COUNT_W'(fill_reg + 1'b1);
            end
            else
            begin
                res_next.trace_count = COUNT_W'(fill_reg);
            end
        end
        else if (cmd.capture && rd_ok_reg)
        begin
            res_next.trace_pc   = ram_rdata[RW-1:WORD_W];
            res_next.trace_word = ram_rdata[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_valid_reg <= '0;
            run_reg      <= 1'b0;
            ss_reg       <= 1'b0;
            skip_reg     <= 1'b0;
            oact_reg     <= 1'b0;
            opend_reg    <= 1'b0;
            tgt_reg      <= '0;
            ticks_reg    <= TICK_W'(TICK_CAP);
            head_reg     <= '0;
            fill_reg     <= '0;
        end
        else if (cmd.exec)
        begin
            bp_valid_reg <= bp_valid_next;
            run_reg      <= run_next;
            ss_reg       <= ss_next;
            skip_reg     <= skip_next;
            oact_reg     <= oact_next;
            opend_reg    <= opend_next;
            tgt_reg      <= tgt_next;
            ticks_reg    <= ticks_next;
            if (grant)
            begin
                head_reg <= (head_reg == TW'(TRACE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                if (fill_reg < FW'(TRACE_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= in_data;
        end
        if (cmd.exec)
        begin
            rd_ok_reg <= rd_ok;
        end
        if (cmd.exec && bp_write)
        begin
            for (int i = 0; i < BP_ENTRIES; i++)
            begin
                if (bp_free_oh[i])
                begin
                    bp_addr_reg[i] <= item_reg.cur_pc;
                end
            end
        end
        res_reg <= res_next;
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign stat.is_read = (item_reg.mode == MODE_READ_TRC);
    assign out_data     = out_reg;

    `DRC_ASSERT_ALWAYS(a_fill_bound, fill_reg <= FW'(TRACE_DEPTH), "trace fill beyond depth")
    `DRC_ASSERT_SAME(a_grant_mode, cmd.exec && grant,
        item_reg.mode == MODE_TICK || item_reg.mode == MODE_RUN_ONE, "grant outside tick or run one")
    `DRC_ASSERT_NEXT(a_hit_stops, cmd.exec && hit,
        !run_reg && !oact_reg && !res_reg.execute_now, "breakpoint hit left the run going")
    `DRC_ASSERT_NEXT(a_grant_clears, cmd.exec && grant, ticks_reg == '0, "grant kept pacing count")

endmodule

// ===== tb/debug_run_control_test.sv =====
// Self-checking testbench for debug_run_control: breakpoints, run/step/step-over
// control, tick pacing and the trace ring, checked against an in-bench predictor.
// Depends on drc_pkg and the debug_run_control RTL.
module debug_run_control_test;
    import drc_pkg::*;

    localparam int BP_N         = BP_ENTRIES_DFLT;
    localparam int TRC_N        = TRACE_DEPTH_DFLT;
    localparam int RANDOM_ITEMS = 1700;
    localparam int LONG_HOLD    = 250;
    localparam int HOLD_AT      = 400;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    drc_in_t in_data;
    logic out_valid;
    logic out_stall;
    drc_out_t out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    debug_run_control DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    // Predictor copy of the run control state
    logic [TICK_W-1:0] pace_cfg = PACE_RESET;
    bit                bp_on [BP_N];
    logic [PC_W-1:0]   bp_pc [BP_N];
    bit                run_flag;
    bit                step_req;
    bit                skip_once;
    bit                over_act;
    bit                over_pend;
    logic [SP_W-1:0]   over_depth;
    int unsigned       since_exec = TICK_CAP;
    logic [PC_W-1:0]   ring_pc [TRC_N];
    logic [WORD_W-1:0] ring_word [TRC_N];
    int unsigned       ring_head;
    int unsigned       ring_fill;

    drc_out_t exp_results[$];
    logic [PC_W-1:0] hot_pc [8];
    bit calm;
    int n_sent;
    int n_results;
    int n_errors;
    int n_grants;
    int n_stops;
    int n_full;

    typedef struct {
        drc_in_t  req;
        bit       typed;
        drc_out_t res;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic bit bp_hit(logic [PC_W-1:0] pc);
        for (int i = 0; i < BP_N; i++)
            if (bp_on[i] && bp_pc[i] == pc)
                return 1'b1;
        return 1'b0;
    endfunction

    // Stop the run at a breakpoint unless the one-shot skip is armed.
    function automatic bit bp_stop(logic [PC_W-1:0] pc);
        if (!bp_hit(pc))
            return 1'b0;
        if (skip_once) begin
            skip_once = 1'b0;
            return 1'b0;
        end
        run_flag = 1'b0;
        over_act = 1'b0;
        return 1'b1;
    endfunction

    function automatic void record_exec(logic [PC_W-1:0] pc, logic [WORD_W-1:0] word);
        since_exec = 0;
        ring_pc[ring_head] = pc;
        ring_word[ring_head] = (pc == {PC_W{1'b1}}) ? '0 : word;
        ring_head = (ring_head + 1) % TRC_N;
        if (ring_fill < TRC_N)
            ring_fill++;
        n_grants++;
    endfunction

    function automatic drc_out_t run_control_step(drc_in_t r);
        drc_out_t    o;
        int unsigned interval;
        int          slot;
        int unsigned pos;
        o = '0;
        case (r.mode)
            MODE_TICK: begin
                interval = (pace_cfg == 0) ? 1 : (pace_cfg > TICK_CAP) ? TICK_CAP : pace_cfg;
                if (since_exec < TICK_CAP)
                    since_exec++;
                if (over_pend) begin
                    over_pend = 1'b0;
                    over_act = 1'b1;
                    over_depth = r.cur_sp;
                    run_flag = 1'b1;
                    skip_once = 1'b1;
                end
                if (!run_flag) begin
                    if (step_req) begin
                        step_req = 1'b0;
                        o.execute_now = 1'b1;
                    end
                end else if (since_exec >= interval) begin
                    o.hit_breakpoint = bp_stop(r.cur_pc);
                    o.execute_now = run_flag;
                end
                if (o.execute_now)
                    record_exec(r.cur_pc, r.fetched_word);
            end
            MODE_BP_ADD: begin
                if (!bp_hit(r.cur_pc)) begin
                    slot = -1;
                    for (int i = 0; i < BP_N && slot < 0; i++)
                        if (!bp_on[i])
                            slot = i;
                    if (slot < 0) begin
                        o.status = 1'b1;
                        n_full++;
                    end else begin
                        bp_on[slot] = 1'b1;
                        bp_pc[slot] = r.cur_pc;
                    end
                end
            end
            MODE_BP_REMOVE: begin
                for (int i = 0; i < BP_N; i++)
                    if (bp_on[i] && bp_pc[i] == r.cur_pc)
                        bp_on[i] = 1'b0;
            end
            MODE_BP_CLEAR: begin
                foreach (bp_on[i])
                    bp_on[i] = 1'b0;
            end
            MODE_STEP: begin
                if (!run_flag)
                    step_req = 1'b1;
            end
            MODE_STEP_OVER: begin
                if (!run_flag && !over_act && !over_pend)
                    over_pend = 1'b1;
            end
            MODE_RESUME: begin
                if (!run_flag) begin
                    run_flag = 1'b1;
                    skip_once = 1'b1;
                end
            end
            MODE_PAUSE: begin
                if (run_flag) begin
                    run_flag = 1'b0;
                    over_act = 1'b0;
                    over_pend = 1'b0;
                end
            end
            MODE_RUN_ONE: begin
                if (run_flag) begin
                    o.hit_breakpoint = bp_stop(r.cur_pc);
                    o.execute_now = run_flag;
                    if (o.execute_now)
                        record_exec(r.cur_pc, r.fetched_word);
                end
            end
            MODE_RETIRE: begin
                if (over_act && r.cur_sp <= over_depth) begin
                    over_act = 1'b0;
                    run_flag = 1'b0;
                end
            end
            MODE_READ_TRC: begin
                if (r.trace_index < ring_fill) begin
                    pos = (ring_head + TRC_N - ring_fill + r.trace_index) % TRC_N;
                    o.trace_pc = ring_pc[pos];
                    o.trace_word = ring_word[pos];
                end
            end
            default: ;
        endcase
        if (o.hit_breakpoint)
            n_stops++;
        o.running = run_flag;
        o.stepping_over = over_act;
        o.step_over_waiting = over_pend;
        o.trace_count = COUNT_W'(ring_fill);
        return o;
    endfunction

    task automatic check_result(drc_out_t got);
        drc_out_t want;
        n_results++;
        if (exp_results.size() == 0) begin
            if (n_errors < 10)
                $display("result %0d arrived with nothing expected", n_results);
            n_errors++;
            return;
        end
        want = exp_results[0];
        exp_results.delete(0);
        if (got !== want) begin
            if (n_errors < 10)
                $display("result %0d: expected %p, got %p", n_results, want, got);
            n_errors++;
        end
    endtask

    // Offer one request and hold it until the block takes it.
    task automatic send_req(drc_in_t r, bit typed = 1'b0, drc_out_t fixed = '0);
        bit took;
        drc_out_t predicted;
        while (!calm && $urandom_range(0, 99) < 38) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end while (!took);
        predicted = run_control_step(r);
        exp_results.insert(exp_results.size(), typed ? fixed : predicted);
        n_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (exp_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_pace(logic [31:0] value);
        bit ok;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'({CFG_IDX_PACE, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do begin
            @(negedge clk);
            ok = pready;
            @(posedge clk);
        end while (!ok);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pace_cfg = value[TICK_W-1:0];
    endtask

    function automatic logic [SP_W-1:0] rand_sp();
        return SP_W'($urandom_range(0, 16));
    endfunction

    function automatic drc_in_t make_req(logic [3:0] m, logic [SP_W-1:0] sp);
        drc_in_t r;
        r.mode = m;
        r.cur_pc = ($urandom_range(0, 3) != 0) ? hot_pc[$urandom_range(0, 7)] : PC_W'($urandom);
        r.cur_sp = sp;
        r.fetched_word = WORD_W'($urandom);
        r.trace_index = IDX_W'($urandom);
        return r;
    endfunction

    function automatic drc_out_t fixed_res(bit ex, bit run, logic [PC_W-1:0] tpc,
                                           logic [WORD_W-1:0] tw, logic [COUNT_W-1:0] cnt);
        drc_out_t o;
        o = '0;
        o.execute_now = ex;
        o.running = run;
        o.trace_pc = tpc;
        o.trace_word = tw;
        o.trace_count = cnt;
        return o;
    endfunction

    function automatic void add_row(logic [3:0] m, logic [PC_W-1:0] pc, logic [SP_W-1:0] sp,
                                    logic [WORD_W-1:0] word, logic [IDX_W-1:0] idx,
                                    bit typed = 1'b0, drc_out_t res = '0);
        dir_row_t row;
        row.req = '{mode: m, cur_pc: pc, cur_sp: sp, fetched_word: word, trace_index: idx};
        row.typed = typed;
        row.res = res;
        dir_rows.push_back(row);
    endfunction

    // One short well-formed sequence with random content, or a little noise.
    task automatic play_burst();
        int      kind;
        int      depth;
        drc_in_t r;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            if ($urandom_range(0, 2) == 0)
                send_req(make_req(MODE_BP_ADD, rand_sp()));
            send_req(make_req(MODE_RESUME, rand_sp()));
            repeat ($urandom_range(3, 24))
                send_req(make_req(($urandom_range(0, 9) == 0) ? MODE_RUN_ONE : MODE_TICK,
                                  rand_sp()));
            case ($urandom_range(0, 3))
                0: send_req(make_req(MODE_PAUSE, rand_sp()));
                1: send_req(make_req(MODE_BP_REMOVE, rand_sp()));
                default: ;
            endcase
        end else if (kind < 55) begin
            depth = $urandom_range(0, 16);
            send_req(make_req(MODE_STEP_OVER, SP_W'(depth)));
            send_req(make_req(MODE_TICK, SP_W'(depth)));
            repeat ($urandom_range(2, 12))
                send_req(make_req(($urandom_range(0, 2) == 0) ? MODE_RETIRE : MODE_TICK,
                                  rand_sp()));
            send_req(make_req(MODE_RETIRE, SP_W'($urandom_range(0, depth))));
        end else if (kind < 67) begin
            send_req(make_req(MODE_STEP, rand_sp()));
            repeat ($urandom_range(1, 2))
                send_req(make_req(MODE_TICK, rand_sp()));
            send_req(make_req(MODE_READ_TRC, rand_sp()));
        end else if (kind < 72) begin
            // overfill the breakpoint table, then wipe it in half of the cases
            repeat (BP_N + 1) begin
                r = make_req(MODE_BP_ADD, rand_sp());
                r.cur_pc = PC_W'($urandom);
                send_req(r);
            end
            if ($urandom_range(0, 1) == 0)
                send_req(make_req(MODE_BP_CLEAR, rand_sp()));
        end else if (kind < 82) begin
            repeat ($urandom_range(1, 4))
                send_req(make_req(MODE_READ_TRC, rand_sp()));
        end else begin
            repeat ($urandom_range(1, 4))
                send_req(make_req(4'($urandom_range(0, 15)), SP_W'($urandom_range(0, 31))));
        end
    endtask

    initial begin : stimulus
        int unsigned pace_plan[6];
        int          n_dir;
        pace_plan = '{1, 0, 3, 1000, 1023, 5};
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        out_stall <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        hot_pc[0] = '0;
        hot_pc[1] = {PC_W{1'b1}};
        for (int i = 2; i < 8; i++)
            hot_pc[i] = PC_W'($urandom);

        // trace read and tick right after reset, then a single step at the top of memory
        add_row(MODE_READ_TRC, 12'h000, 5'd0, 16'h0000, 5'd0, 1'b1,
                fixed_res(1'b0, 1'b0, 12'h000, 16'h0000, 6'd0));
        add_row(MODE_TICK, 12'h000, 5'd0, 16'h1234, 5'd0, 1'b1,
                fixed_res(1'b0, 1'b0, 12'h000, 16'h0000, 6'd0));
        add_row(MODE_STEP, 12'h000, 5'd0, 16'h0000, 5'd0, 1'b1,
                fixed_res(1'b0, 1'b0, 12'h000, 16'h0000, 6'd0));
        add_row(MODE_TICK, 12'hFFF, 5'd16, 16'hFFFF, 5'd31, 1'b1,
                fixed_res(1'b1, 1'b0, 12'h000, 16'h0000, 6'd1));
        add_row(MODE_READ_TRC, 12'h000, 5'd0, 16'h0000, 5'd0, 1'b1,
                fixed_res(1'b0, 1'b0, 12'hFFF, 16'h0000, 6'd1));
        add_row(MODE_READ_TRC, 12'h000, 5'd0, 16'h0000, 5'd31, 1'b1,
                fixed_res(1'b0, 1'b0, 12'h000, 16'h0000, 6'd1));
        add_row(MODE_BP_ADD, 12'h123, 5'd0, 16'h0000, 5'd0, 1'b1,
                fixed_res(1'b0, 1'b0, 12'h000, 16'h0000, 6'd1));
        add_row(MODE_BP_ADD, 12'h123, 5'd0, 16'h0000, 5'd0, 1'b1,
                fixed_res(1'b0, 1'b0, 12'h000, 16'h0000, 6'd1));
        add_row(MODE_BP_REMOVE, 12'h456, 5'd0, 16'h0000, 5'd0, 1'b1,
                fixed_res(1'b0, 1'b0, 12'h000, 16'h0000, 6'd1));
        add_row(MODE_RESUME, 12'h000, 5'd0, 16'h0000, 5'd0, 1'b1,
                fixed_res(1'b0, 1'b1, 12'h000, 16'h0000, 6'd1));
        add_row(MODE_RESUME, 12'h000, 5'd0, 16'h0000, 5'd0);
        add_row(MODE_STEP, 12'h000, 5'd0, 16'h0000, 5'd0);
        add_row(MODE_TICK, 12'h123, 5'd3, 16'hABCD, 5'd0);
        add_row(MODE_TICK, 12'h123, 5'd3, 16'hABCD, 5'd0);
        add_row(MODE_RUN_ONE, 12'h123, 5'd3, 16'h5A5A, 5'd0);
        add_row(MODE_PAUSE, 12'h000, 5'd0, 16'h0000, 5'd0);
        add_row(MODE_RUN_ONE, 12'h200, 5'd0, 16'h0001, 5'd0);
        add_row(MODE_STEP_OVER, 12'h200, 5'd5, 16'h0000, 5'd0);
        add_row(MODE_STEP_OVER, 12'h200, 5'd5, 16'h0000, 5'd0);
        add_row(MODE_TICK, 12'h200, 5'd5, 16'h2222, 5'd0);
        add_row(MODE_RETIRE, 12'h202, 5'd6, 16'h0000, 5'd0);
        add_row(MODE_RETIRE, 12'h202, 5'd5, 16'h0000, 5'd0);
        add_row(MODE_RETIRE, 12'h204, 5'd0, 16'h0000, 5'd0);
        add_row(MODE_RESUME, 12'h000, 5'd0, 16'h0000, 5'd0);
        add_row(MODE_PAUSE, 12'h000, 5'd0, 16'h0000, 5'd0);
        add_row(4'hF, 12'hFFF, 5'd31, 16'hFFFF, 5'd31);
        add_row(MODE_BP_CLEAR, 12'h000, 5'd0, 16'h0000, 5'd0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        n_dir = n_sent;

        // each pace setting gets its own phase; the third runs with no idling at all
        foreach (pace_plan[p]) begin
            drain();
            write_pace(pace_plan[p]);
            calm = (p == 2);
            while (n_sent < n_dir + (p + 1) * RANDOM_ITEMS / $size(pace_plan))
                play_burst();
        end
        calm = 1'b0;
        drain();
        repeat (20) @(posedge clk);

        $display("run covered %0d requests over %0d pace settings and %0d results",
                 n_sent, $size(pace_plan) + 1, n_results);
        $display("  %0d grants, %0d breakpoint stops, %0d adds to a full breakpoint list",
                 n_grants, n_stops, n_full);
        if (n_errors == 0 && exp_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin : result_side
        drc_out_t got;
        bit       took;
        bit       held_once;
        int       hold_left;
        held_once = 1'b0;
        hold_left = 0;
        @(posedge clk iff rst_n);
        forever begin
            @(negedge clk);
            took = out_valid && !out_stall;
            got = out_data;
            @(posedge clk);
            if (took)
                check_result(got);
            // hold off once for a long stretch so the block backs up into its input
            if (!held_once && n_results >= HOLD_AT) begin
                held_once = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(0, 99) < 38);
            end
        end
    end

    initial begin : watchdog
        #600000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/drc_pkg.sv
rtl/drc_ram.sv
rtl/drc_ctrl.sv
rtl/drc_dpath.sv
rtl/debug_run_control.sv
tb/debug_run_control_test.sv
